/* hdl/fwpd_pkg.sv */
// ----------------------------------------------------------------------------
// fwpd_pkg
// Shared codes, types and saturation helpers for the four-wheel PD speed
// controller.
// ----------------------------------------------------------------------------
`default_nettype none

package fwpd_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FORWARD_SPEED     = 3'd0;
    localparam logic [2:0] CFG_LATERAL_SPEED     = 3'd1;
    localparam logic [2:0] CFG_STRAFE_TURN_RATIO = 3'd2;
    localparam logic [2:0] CFG_SPIN_SPEED        = 3'd3;
    localparam logic [2:0] CFG_PROP_GAIN         = 3'd4;
    localparam logic [2:0] CFG_DERIV_GAIN        = 3'd5;
    localparam logic [2:0] CFG_LATERAL_GAIN      = 3'd6;

    // Motion mode codes.
    localparam logic [1:0] MODE_STRAIGHT     = 2'd0;
    localparam logic [1:0] MODE_STRAFE_LEFT  = 2'd1;
    localparam logic [1:0] MODE_STRAFE_RIGHT = 2'd2;
    localparam logic [1:0] MODE_KEEP         = 2'd3;

    // Spin mode codes that update the errors; the upper four keep them.
    localparam logic [2:0] SPIN_LEFT_PLUS_A  = 3'd0;
    localparam logic [2:0] SPIN_LEFT_PLUS_B  = 3'd1;
    localparam logic [2:0] SPIN_LEFT_MINUS_A = 3'd2;
    localparam logic [2:0] SPIN_LEFT_MINUS_B = 3'd3;

    // Reset values of the configuration registers that are not zero.
    localparam logic [11:0] RATIO_RESET      = 12'd256;
    localparam logic [11:0] SPIN_SPEED_RESET = 12'd250;

    typedef struct packed {
        logic [15:0] prop;
        logic [15:0] deriv;
        logic [15:0] lateral;
    } gain_t;

    function automatic logic signed [15:0] sat16(input logic signed [26:0] v);
        logic signed [15:0] r;
        if (v > 27'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -27'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sh0_7fff_ffff) begin
            r = 32'sh7fff_ffff;
        end else if (v < -35'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/four_wheel_pd_speed_control.sv */
// ----------------------------------------------------------------------------
// four_wheel_pd_speed_control
// Mecanum four-wheel speed controller: per-wheel target mixing, saturated
// errors kept per wheel, and PD or proportional drives per wheel.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  s_        in         s_tvalid/s_tready    s_tdata wheel speeds, steer; s_tuser modes
//  m_        out        m_tvalid/m_tready    m_tdata drive0..drive3
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Three registered stages (input, error, drive): one transfer per cycle
//  sustained while m_tready stays high; an item reaches m_tvalid through all three.
//  The error stage updates the stored wheel errors as each item passes it, unless its mode keeps them.
//  A stall on m_tready holds each stage only as far back as needed.
//  Reset clears the stage valid bits and stored errors and loads the config reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module four_wheel_pd_speed_control
    import fwpd_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [15:0] wheel0_speed, [31:16] wheel1_speed, [47:32] wheel2_speed,
    // [63:48] wheel3_speed, [76:64] steer, [79:77] zero
    input  wire logic [79:0]  s_tdata,
    // [0] spinning, [2:1] motion_mode, [5:3] spin_mode
    input  wire logic [5:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] drive0, [63:32] drive1, [95:64] drive2, [127:96] drive3
    output logic [127:0]      m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    // Configuration registers.
    logic [11:0] forward_speed_reg;
    logic [11:0] lateral_speed_reg;
    logic [11:0] ratio_reg;
    logic [11:0] spin_speed_reg;
    gain_t       gains_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            forward_speed_reg <= '0;
            lateral_speed_reg <= '0;
            ratio_reg         <= RATIO_RESET;
            spin_speed_reg    <= SPIN_SPEED_RESET;
            gains_reg         <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FORWARD_SPEED:     forward_speed_reg <= cfg_data[11:0];
                CFG_LATERAL_SPEED:     lateral_speed_reg <= cfg_data[11:0];
                CFG_STRAFE_TURN_RATIO: ratio_reg         <= cfg_data[11:0];
                CFG_SPIN_SPEED:        spin_speed_reg    <= cfg_data[11:0];
                CFG_PROP_GAIN:         gains_reg.prop    <= cfg_data;
                CFG_DERIV_GAIN:        gains_reg.deriv   <= cfg_data;
                CFG_LATERAL_GAIN:      gains_reg.lateral <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Stage enables, from the output side back.
    logic a_valid_reg;
    logic b_valid_reg;
    logic c_valid_reg;
    logic en_a;
    logic en_b;
    logic en_c;

    assign en_c     = !c_valid_reg || m_tready;
    assign en_b     = !b_valid_reg || en_c;
    assign en_a     = !a_valid_reg || en_b;
    assign s_tready = en_a;

    // Input stage.
    logic signed [15:0] in_spd_reg [4];
    logic signed [12:0] in_steer_reg;
    logic               in_spinning_reg;
    logic [1:0]         in_mmode_reg;
    logic [2:0]         in_smode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en_a) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && en_a) begin
            in_spd_reg[0]   <= s_tdata[15:0];
            in_spd_reg[1]   <= s_tdata[31:16];
            in_spd_reg[2]   <= s_tdata[47:32];
            in_spd_reg[3]   <= s_tdata[63:48];
            in_steer_reg    <= s_tdata[76:64];
            in_spinning_reg <= s_tuser[0];
            in_mmode_reg    <= s_tuser[2:1];
            in_smode_reg    <= s_tuser[5:3];
        end
    end

    // Error stage: targets and saturated errors.
    logic signed [15:0] last_error_reg [4];
    logic signed [15:0] err_next [4];
    logic signed [25:0] ratio_prod;
    logic               update;

    assign ratio_prod = $signed({1'b0, ratio_reg}) * in_steer_reg;

    always_comb begin
        update = in_spinning_reg ? (in_smode_reg inside {[SPIN_LEFT_PLUS_A:SPIN_LEFT_MINUS_B]})
                                 : (in_mmode_reg != MODE_KEEP);
    end

    always_comb begin
        logic signed [26:0] spd_x;
        logic signed [26:0] steer_x;
        logic signed [26:0] fwd_x;
        logic signed [26:0] lat_x;
        logic signed [26:0] r_x;
        logic signed [26:0] sp_x;
        logic signed [26:0] diff;
        logic signed [26:0] q8_diff;
        logic signed [26:0] q8_round;
        logic               is_right;
        logic               lat_neg;
        fwd_x   = $signed({15'd0, forward_speed_reg});
        lat_x   = $signed({7'd0, lateral_speed_reg, 8'd0});
        sp_x    = $signed({15'd0, spin_speed_reg});
        steer_x = 27'(in_steer_reg);
        r_x     = 27'(ratio_prod);
        for (int i = 0; i < 4; i++) begin
            spd_x    = 27'(in_spd_reg[i]);
            is_right = (i == 1) || (i == 3);
            // In strafe left, wheels 0 and 3 run against the lateral speed.
            lat_neg  = ((i == 0) || (i == 3)) ^ (in_mmode_reg == MODE_STRAFE_RIGHT);
            q8_diff  = (lat_neg ? -lat_x : lat_x) + (is_right ? -r_x : r_x)
                     - (spd_x <<< 8);
            // Arithmetic shift with a bias on negatives truncates toward zero.
            q8_round = (q8_diff + (q8_diff[26] ? 27'sd255 : 27'sd0)) >>> 8;
            if (in_spinning_reg) begin
                if (in_smode_reg inside {SPIN_LEFT_PLUS_A, SPIN_LEFT_PLUS_B}) begin
                    diff = (is_right ? -sp_x : sp_x) - spd_x;
                end else begin
                    diff = (is_right ? sp_x : -sp_x) - spd_x;
                end
            end else if (in_mmode_reg == MODE_STRAIGHT) begin
                diff = fwd_x + (is_right ? -steer_x : steer_x) - spd_x;
            end else begin
                diff = q8_round;
            end
            err_next[i] = update ? sat16(diff) : last_error_reg[i];
        end
    end

    logic signed [15:0] b_err_reg  [4];
    logic signed [15:0] b_prev_reg [4];
    logic               b_straight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                last_error_reg[i] <= '0;
            end
        end else if (en_b) begin
            b_valid_reg <= a_valid_reg;
            if (a_valid_reg) begin
                for (int i = 0; i < 4; i++) begin
                    last_error_reg[i] <= err_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_b && a_valid_reg) begin
            for (int i = 0; i < 4; i++) begin
                b_err_reg[i]  <= err_next[i];
                b_prev_reg[i] <= last_error_reg[i];
            end
            b_straight_reg <= (in_mmode_reg == MODE_STRAIGHT);
        end
    end

    // Drive stage.
    logic signed [31:0] drive [4];
    logic [127:0]       m_data_reg;

    for (genvar g = 0; g < 4; g++) begin : g_drive
        fwpd_drive u_drive (
            .err      (b_err_reg[g]),
            .prev     (b_prev_reg[g]),
            .straight (b_straight_reg),
            .gains    (gains_reg),
            .drive    (drive[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en_c) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_c && b_valid_reg) begin
            m_data_reg <= {drive[3], drive[2], drive[1], drive[0]};
        end
    end

    assign m_tvalid = c_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

/* hdl/fwpd_drive.sv */
// ----------------------------------------------------------------------------
// fwpd_drive
// Drive of one wheel: PD law in straight mode, proportional law with the
// lateral gain otherwise, saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module fwpd_drive
    import fwpd_pkg::*;
(
    input  wire logic signed [15:0] err,
    input  wire logic signed [15:0] prev,
    input  wire logic               straight,
    input  wire gain_t              gains,
    output logic signed [31:0]      drive
);

    logic signed [16:0] diff;
    logic signed [32:0] p_term;
    logic signed [33:0] d_term;
    logic signed [32:0] l_term;
    logic signed [34:0] pd_sum;
    logic signed [34:0] sel;

    assign diff   = $signed({err[15], err}) - $signed({prev[15], prev});
    assign p_term = $signed({1'b0, gains.prop}) * err;
    assign d_term = $signed({1'b0, gains.deriv}) * diff;
    assign l_term = $signed({1'b0, gains.lateral}) * err;
    assign pd_sum = $signed({{2{p_term[32]}}, p_term}) + $signed({d_term[33], d_term});
    assign sel    = straight ? pd_sum : $signed({{2{l_term[32]}}, l_term});
    assign drive  = sat32(sel);

endmodule

`default_nettype wire

/* sim/tb_four_wheel_pd_speed_control.sv */
// ----------------------------------------------------------------------------
// tb_four_wheel_pd_speed_control
// Self-checking bench for the mecanum PD speed controller. A queue-fed driver
// offers control ticks in random bursts and a monitor compares every drive
// transfer against a bit-accurate predictor of the wheel errors and drives.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_four_wheel_pd_speed_control
    import fwpd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned LONG_HOLD      = 300;

    localparam logic [2:0] CFG_UNUSED   = 3'd7;
    localparam logic [2:0] SPIN_KEEP_LO = 3'd4;
    localparam logic [2:0] SPIN_KEEP_HI = 3'd7;

    typedef struct packed {
        logic [3:0][15:0] speed;
        logic [12:0]      steer;
        logic             spinning;
        logic [1:0]       motion;
        logic [2:0]       spin;
    } tick_t;

    typedef logic [3:0][31:0] drives_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [79:0]  s_tdata   = '0;
    logic [5:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [127:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [15:0]  cfg_data  = '0;

    // Predictor copy of the registers and the stored wheel errors.
    logic [11:0]        fwd_speed    = '0;
    logic [11:0]        lat_speed    = '0;
    logic [11:0]        strafe_ratio = RATIO_RESET;
    logic [11:0]        spin_mag     = SPIN_SPEED_RESET;
    logic [15:0]        kp           = '0;
    logic [15:0]        kd           = '0;
    logic [15:0]        k_lat        = '0;
    logic signed [15:0] wheel_err [4];

    tick_t       tick_queue [$];
    drives_t     drive_queue [$];
    tick_t       on_bus;
    drives_t     want;
    int unsigned burst_left  = 1;
    int unsigned gap_left    = 0;
    int unsigned pattern     = 0;
    int unsigned pattern_left = 0;
    int unsigned long_hold   = 0;
    int unsigned stall_reqs  = 0;
    int unsigned stall_seen  = 0;
    int unsigned idle_cycles = 0;
    int unsigned mismatches  = 0;

    four_wheel_pd_speed_control u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        // [15:0] wheel0_speed .. [63:48] wheel3_speed, [76:64] steer, [79:77] zero
        .s_tdata   (s_tdata),
        // [0] spinning, [2:1] motion_mode, [5:3] spin_mode
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        // [31:0] drive0, [63:32] drive1, [95:64] drive2, [127:96] drive3
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 64'sd32767) begin
            return 16'sh7fff;
        end else if (v < -64'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Strafe targets are held in Q.8; the division truncates toward zero.
    function automatic logic signed [15:0] strafe_err(input longint target_q8,
                                                      input longint speed);
        return clamp16((target_q8 - speed * 256) / 256);
    endfunction

    // Updates the stored wheel errors for one tick and returns its drives.
    function automatic drives_t predict_drives(input tick_t t);
        longint  spd [4];
        longint  prev [4];
        longint  st;
        longint  fwd;
        longint  lat_q8;
        longint  rterm;
        longint  left;
        longint  e;
        longint  d;
        drives_t res;
        st     = $signed(t.steer);
        fwd    = longint'(fwd_speed);
        lat_q8 = longint'(lat_speed) * 256;
        rterm  = longint'(strafe_ratio) * st;
        for (int i = 0; i < 4; i++) begin
            spd[i]  = $signed(t.speed[i]);
            prev[i] = wheel_err[i];
        end
        if (!t.spinning) begin
            case (t.motion)
                MODE_STRAIGHT: begin
                    wheel_err[0] = clamp16(fwd + st - spd[0]);
                    wheel_err[2] = clamp16(fwd + st - spd[2]);
                    wheel_err[1] = clamp16(fwd - st - spd[1]);
                    wheel_err[3] = clamp16(fwd - st - spd[3]);
                end
                MODE_STRAFE_LEFT: begin
                    wheel_err[0] = strafe_err(-lat_q8 + rterm, spd[0]);
                    wheel_err[2] = strafe_err(lat_q8 + rterm, spd[2]);
                    wheel_err[1] = strafe_err(lat_q8 - rterm, spd[1]);
                    wheel_err[3] = strafe_err(-lat_q8 - rterm, spd[3]);
                end
                MODE_STRAFE_RIGHT: begin
                    wheel_err[0] = strafe_err(lat_q8 + rterm, spd[0]);
                    wheel_err[2] = strafe_err(-lat_q8 + rterm, spd[2]);
                    wheel_err[1] = strafe_err(-lat_q8 - rterm, spd[1]);
                    wheel_err[3] = strafe_err(lat_q8 - rterm, spd[3]);
                end
                default: begin
                end
            endcase
        end else if (t.spin <= SPIN_LEFT_MINUS_B) begin
            left = (t.spin <= SPIN_LEFT_PLUS_B) ? longint'(spin_mag) : -longint'(spin_mag);
            wheel_err[0] = clamp16(left - spd[0]);
            wheel_err[2] = clamp16(left - spd[2]);
            wheel_err[1] = clamp16(-left - spd[1]);
            wheel_err[3] = clamp16(-left - spd[3]);
        end
        // The gain follows the motion mode even while spinning.
        for (int i = 0; i < 4; i++) begin
            e = wheel_err[i];
            if (t.motion == MODE_STRAIGHT) begin
                d = longint'(kp) * e + longint'(kd) * (e - prev[i]);
            end else begin
                d = longint'(k_lat) * e;
            end
            res[i] = clamp32(d);
        end
        return res;
    endfunction

    function automatic tick_t mk(input int s0, input int s1, input int s2, input int s3,
                                 input int steer, input logic spinning,
                                 input logic [1:0] motion, input logic [2:0] spin);
        tick_t t;
        t.speed[0] = s0[15:0];
        t.speed[1] = s1[15:0];
        t.speed[2] = s2[15:0];
        t.speed[3] = s3[15:0];
        t.steer    = steer[12:0];
        t.spinning = spinning;
        t.motion   = motion;
        t.spin     = spin;
        return t;
    endfunction

    function automatic logic [15:0] rand_speed();
        int unsigned r;
        case ($urandom_range(0, 9))
            0:       r = $urandom_range(0, 1) ? 32'h7fff : 32'h8000;
            1, 2, 3: r = $urandom;
            default: r = $urandom_range(0, 4000) - 2000;
        endcase
        return r[15:0];
    endfunction

    function automatic tick_t rand_tick();
        tick_t       t;
        int unsigned r;
        for (int i = 0; i < 4; i++) begin
            t.speed[i] = rand_speed();
        end
        case ($urandom_range(0, 5))
            0:       r = $urandom_range(0, 1) ? 32'h0fff : 32'h1000;
            1, 2:    r = $urandom;
            default: r = $urandom_range(0, 400) - 200;
        endcase
        t.steer    = r[12:0];
        t.spinning = ($urandom_range(0, 3) == 0);
        t.motion   = 2'($urandom_range(0, 3));
        t.spin     = 3'($urandom_range(0, 7));
        return t;
    endfunction

    // Mostly modest register values, so that drives do not always saturate.
    function automatic logic [15:0] pick_reg(input int unsigned top, input int unsigned modest);
        int unsigned r;
        case ($urandom_range(0, 5))
            0:       r = 0;
            1:       r = top;
            5:       r = $urandom_range(0, top);
            default: r = $urandom_range(0, modest);
        endcase
        return r[15:0];
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        case (idx)
            CFG_FORWARD_SPEED:     fwd_speed    = val[11:0];
            CFG_LATERAL_SPEED:     lat_speed    = val[11:0];
            CFG_STRAFE_TURN_RATIO: strafe_ratio = val[11:0];
            CFG_SPIN_SPEED:        spin_mag     = val[11:0];
            CFG_PROP_GAIN:         kp           = val;
            CFG_DERIV_GAIN:        kd           = val;
            CFG_LATERAL_GAIN:      k_lat        = val;
            default: begin
            end
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_all(input logic [15:0] fwd, input logic [15:0] lat,
                             input logic [15:0] ratio, input logic [15:0] spin,
                             input logic [15:0] p, input logic [15:0] d,
                             input logic [15:0] l);
        write_reg(CFG_FORWARD_SPEED, fwd);
        write_reg(CFG_LATERAL_SPEED, lat);
        write_reg(CFG_STRAFE_TURN_RATIO, ratio);
        write_reg(CFG_SPIN_SPEED, spin);
        write_reg(CFG_PROP_GAIN, p);
        write_reg(CFG_DERIV_GAIN, d);
        write_reg(CFG_LATERAL_GAIN, l);
    endtask

    // Waits until the sender is empty and every drive has come back.
    task automatic wait_idle();
        while (tick_queue.size() != 0 || s_tvalid || drive_queue.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic push_random(input int unsigned count);
        repeat (count) tick_queue.push_back(rand_tick());
    endtask

    // Driver: predicts each tick as its transfer completes, then offers the next.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                drive_queue.push_back(predict_drives(on_bus));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (tick_queue.size() > 0) begin
                    on_bus = tick_queue.pop_front();
                    s_tdata  <= {3'b000, on_bus.steer, on_bus.speed};
                    s_tuser  <= {on_bus.spin, on_bus.motion, on_bus.spinning};
                    s_tvalid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: a changing ready pattern, with a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (long_hold > 0) begin
            long_hold--;
            m_tready <= 1'b0;
        end else if (stall_reqs != stall_seen) begin
            stall_seen = stall_reqs;
            long_hold  = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern      = $urandom_range(0, 3);
                pattern_left = $urandom_range(20, 80);
            end else begin
                pattern_left--;
            end
            case (pattern)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 9) < 7);
                2:       m_tready <= ($urandom_range(0, 9) < 3);
                default: m_tready <= ~m_tready;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (drive_queue.size() == 0) begin
                $error("drive transfer with none expected: %h", m_tdata);
                mismatches++;
            end else begin
                want = drive_queue.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (m_tdata[32*i +: 32] !== want[i]) begin
                        $error("drive%0d: expected %0d, actual %0d", i,
                               $signed(want[i]), $signed(m_tdata[32*i +: 32]));
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** four_wheel_pd_speed_control: FAILED **");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        for (int i = 0; i < 4; i++) begin
            wheel_err[i] = '0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset register values: drives are zero but the errors build up.
        tick_queue.push_back(mk(10, -20, 30, -40, 0, 1'b1, MODE_STRAIGHT, SPIN_LEFT_PLUS_A));
        tick_queue.push_back(mk(0, 0, 0, 0, 100, 1'b0, MODE_STRAFE_LEFT, SPIN_LEFT_PLUS_A));
        tick_queue.push_back(mk(5, 5, 5, 5, -3, 1'b0, MODE_STRAIGHT, SPIN_LEFT_PLUS_A));
        tick_queue.push_back(mk(1, 2, 3, 4, 9, 1'b0, MODE_KEEP, SPIN_LEFT_PLUS_A));
        wait_idle();

        write_reg(CFG_FORWARD_SPEED, 16'd1000);
        write_reg(CFG_LATERAL_SPEED, 16'd300);
        write_reg(CFG_PROP_GAIN, 16'd3);
        write_reg(CFG_DERIV_GAIN, 16'd5);
        write_reg(CFG_LATERAL_GAIN, 16'd7);
        // An index beyond the register map must leave everything unchanged.
        write_reg(CFG_UNUSED, 16'hffff);

        tick_queue.push_back(mk(0, 0, 0, 0, 0, 1'b0, MODE_STRAIGHT, SPIN_LEFT_PLUS_A));
        tick_queue.push_back(mk(0, 0, 0, 0, 4095, 1'b0, MODE_STRAIGHT, SPIN_LEFT_PLUS_A));
        tick_queue.push_back(mk(0, 0, 0, 0, -4096, 1'b0, MODE_STRAIGHT, SPIN_LEFT_PLUS_A));
        tick_queue.push_back(mk(-32768, -32768, -32768, -32768, 4095, 1'b0, MODE_STRAIGHT,
                                SPIN_LEFT_PLUS_A));
        tick_queue.push_back(mk(32767, 32767, 32767, 32767, -4096, 1'b0, MODE_STRAIGHT,
                                SPIN_LEFT_PLUS_A));
        tick_queue.push_back(mk(0, 0, 0, 0, 4095, 1'b0, MODE_STRAFE_LEFT, SPIN_LEFT_PLUS_A));
        // A negative steering term in strafe left; at the reset ratio it is a whole count.
        tick_queue.push_back(mk(0, 0, 0, 0, -1, 1'b0, MODE_STRAFE_LEFT, SPIN_LEFT_PLUS_A));
        tick_queue.push_back(mk(5, -5, 7, -7, -4096, 1'b0, MODE_STRAFE_RIGHT, SPIN_LEFT_PLUS_A));
        tick_queue.push_back(mk(32767, -32768, -32768, 32767, 1, 1'b0, MODE_STRAFE_RIGHT,
                                SPIN_LEFT_PLUS_A));
        tick_queue.push_back(mk(123, -456, 789, -1011, 17, 1'b0, MODE_KEEP, SPIN_LEFT_PLUS_A));
        tick_queue.push_back(mk(0, 0, 0, 0, 0, 1'b1, MODE_STRAIGHT, SPIN_LEFT_PLUS_A));
        tick_queue.push_back(mk(3, 3, -3, -3, 0, 1'b1, MODE_STRAFE_LEFT, SPIN_LEFT_PLUS_B));
        tick_queue.push_back(mk(32767, 32767, 32767, 32767, 0, 1'b1, MODE_STRAIGHT,
                                SPIN_LEFT_MINUS_A));
        tick_queue.push_back(mk(-32768, -32768, -32768, -32768, 0, 1'b1, MODE_STRAIGHT,
                                SPIN_LEFT_MINUS_B));
        tick_queue.push_back(mk(11, 22, 33, 44, 55, 1'b1, MODE_STRAIGHT, SPIN_KEEP_LO));
        tick_queue.push_back(mk(11, 22, 33, 44, 55, 1'b1, MODE_KEEP, SPIN_KEEP_HI));
        tick_queue.push_back(mk(-7, 8, -9, 10, 0, 1'b1, MODE_KEEP, SPIN_LEFT_PLUS_A));
        tick_queue.push_back(mk(100, 100, 100, 100, -50, 1'b0, MODE_STRAIGHT, SPIN_LEFT_PLUS_A));
        tick_queue.push_back(mk(1000, 1000, 1000, 1000, 0, 1'b0, MODE_STRAIGHT,
                                SPIN_LEFT_PLUS_A));
        wait_idle();

        write_all(16'd4095, 16'd4095, 16'd4095, 16'd4095, 16'hffff, 16'hffff, 16'hffff);
        push_random(60);
        wait_idle();

        write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        push_random(40);
        wait_idle();

        for (int phase = 0; phase < 9; phase++) begin
            write_all(pick_reg(4095, 1500), pick_reg(4095, 800), pick_reg(4095, 600),
                      pick_reg(4095, 600), pick_reg(65535, 16), pick_reg(65535, 16),
                      pick_reg(65535, 16));
            push_random(80);
            if (phase == 3) begin
                // Let traffic start, then hold the result side off so the block backs up.
                repeat (30) @(posedge aclk);
                stall_reqs <= stall_reqs + 1;
            end
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && drive_queue.size() == 0) begin
            $display("** four_wheel_pd_speed_control: PASSED **");
        end else begin
            $display("** four_wheel_pd_speed_control: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
hdl/fwpd_pkg.sv
hdl/fwpd_drive.sv
hdl/four_wheel_pd_speed_control.sv
sim/tb_four_wheel_pd_speed_control.sv
